>>> hw/rtl/fpa_pkg.sv
package fpa_pkg;

   localparam int DATA_W              = 32;
   localparam int FRAC_BITS_DEFAULT   = 8;
   localparam int DIV_STEPS_PER_STAGE = 4;

   typedef enum logic [3:0] {
      ACT_ADD   = 4'd0,
      ACT_SUB   = 4'd1,
      ACT_MUL   = 4'd2,
      ACT_DIV   = 4'd3,
      ACT_MIN   = 4'd4,
      ACT_MAX   = 4'd5,
      ACT_ROUND = 4'd6,
      ACT_INCR  = 4'd7,
      ACT_DECR  = 4'd8,
      ACT_CMP   = 4'd9
   } action_type;

endpackage

>>> hw/rtl/fixed_point_alu.sv
// signed 32-bit fixed-point unit with FRAC_BITS fraction bits: add, subtract, multiply,
// divide, min, max, round to integer, increment, decrement and compare, each item also
// carrying less, equal and greater flags for operand_a against operand_b. one item is
// taken every cycle while the output is not stalled; every item passes through the same
// stages: the input register, the compute stage, D = ceil((32 + FRAC_BITS) / 4)
// restoring divider stages of four quotient bits each (10 stages at the default of 8
// fraction bits) and the output register. all actions but the divide are finished in the
// compute stage and ride along. results wrap to 32 bits; a divide by zero returns 0 with
// div_zero set. each stage holds its item when the stage after it is full and stalled,
// so bubbles close up and an item is never dropped or repeated.
module fixed_point_alu #(
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [3:0]                       req_action,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_b,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [fpa_pkg::DATA_W-1:0] rsp_value,
   output logic                             rsp_a_less,
   output logic                             rsp_a_equal,
   output logic                             rsp_a_greater,
   output logic                             rsp_div_zero
);

   localparam int DW        = fpa_pkg::DATA_W;
   localparam int Sps       = fpa_pkg::DIV_STEPS_PER_STAGE;
   // dividend magnitude is |a| shifted up by the fraction bits
   localparam int DivW      = DW + FRAC_BITS;
   localparam int DivStages = (DivW + Sps - 1) / Sps;
   // lane 0 is the compute stage, lanes 1..DivStages the divider
   localparam int NumLanes  = DivStages + 1;
   // valid index 0 input register, 1..NumLanes lanes, last the output register
   localparam int NumStages = NumLanes + 2;
   localparam int Last      = NumStages - 1;

   typedef struct packed {
      logic signed [DW-1:0] value;
      logic                 less;
      logic                 equal;
      logic                 greater;
      logic                 div_zero;
      logic                 is_div;
      logic                 neg;
      logic [DW-1:0]        rem;
      logic [DivW-1:0]      dq;
      logic [DW-1:0]        dvs;
   } lane_type;

   // up to Sps restoring steps; the partial remainder stays below a nonzero divisor
   function automatic logic [DW+DivW-1:0] div_steps(input logic [DW-1:0]   rem,
                                                    input logic [DivW-1:0] dq,
                                                    input logic [DW-1:0]   dvs,
                                                    input int              base);
      logic [DW:0]     trial;
      logic [DW-1:0]   r;
      logic [DivW-1:0] q;
      r = rem;
      q = dq;
      for (int j = 0; j < Sps; j++) begin
         if (base + j < DivW) begin
            trial = {r, q[DivW-1]};
            if (trial >= {1'b0, dvs}) begin
               r = DW'(trial - {1'b0, dvs});
               q = {q[DivW-2:0], 1'b1};
            end else begin
               r = trial[DW-1:0];
               q = {q[DivW-2:0], 1'b0};
            end
         end
      end
      return {r, q};
   endfunction

   logic                   valid_ff [NumStages];
   logic                   rdy      [NumStages];

   // input register
   logic [3:0]             act_ff;
   logic signed [DW-1:0]   a_ff;
   logic signed [DW-1:0]   b_ff;

   lane_type               lane_ff [NumLanes];
   lane_type               lane_in [NumLanes];

   // output register
   logic signed [DW-1:0]   value_ff;
   logic                   less_ff;
   logic                   equal_ff;
   logic                   greater_ff;
   logic                   div_zero_ff;
   logic signed [DW-1:0]   value_in;

   // compute stage signals
   logic signed [2*DW-1:0] product;
   logic [DW-1:0]          a_mag;
   logic [DW-1:0]          b_mag;
   logic signed [DW-1:0]   simple_value;
   logic [DW-1:0]          quot;

   // a stage may take a new item when it is empty or its item moves on
   always_comb begin
      rdy[Last] = !valid_ff[Last] || !rsp_stall;
      for (int k = Last - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   assign req_stall = !rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NumStages; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (rdy[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NumStages; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         act_ff <= req_action;
         a_ff   <= req_operand_a;
         b_ff   <= req_operand_b;
      end
   end

   // compute stage: everything but the divide is finished here
   assign product = a_ff * b_ff;
   assign a_mag   = a_ff[DW-1] ? DW'(0 - $unsigned(a_ff)) : $unsigned(a_ff);
   assign b_mag   = b_ff[DW-1] ? DW'(0 - $unsigned(b_ff)) : $unsigned(b_ff);

   always_comb begin
      unique case (fpa_pkg::action_type'(act_ff))
         fpa_pkg::ACT_ADD:   simple_value = a_ff + b_ff;
         fpa_pkg::ACT_SUB:   simple_value = a_ff - b_ff;
         fpa_pkg::ACT_MUL:   simple_value = product[FRAC_BITS+DW-1:FRAC_BITS];
         fpa_pkg::ACT_MIN:   simple_value = (b_ff < a_ff) ? b_ff : a_ff;
         fpa_pkg::ACT_MAX:   simple_value = (b_ff > a_ff) ? b_ff : a_ff;
         // the shift is kept signed on its own so it stays arithmetic
         fpa_pkg::ACT_ROUND: simple_value = $signed(a_ff >>> FRAC_BITS)
                                            + DW'({1'b0, a_ff[FRAC_BITS-1]});
         fpa_pkg::ACT_INCR:  simple_value = a_ff + DW'(1);
         fpa_pkg::ACT_DECR:  simple_value = a_ff - DW'(1);
         default:            simple_value = '0;
      endcase
   end

   always_comb begin
      lane_in[0].value    = simple_value;
      lane_in[0].less     = a_ff < b_ff;
      lane_in[0].equal    = a_ff == b_ff;
      lane_in[0].greater  = a_ff > b_ff;
      lane_in[0].is_div   = act_ff == fpa_pkg::ACT_DIV;
      lane_in[0].div_zero = (act_ff == fpa_pkg::ACT_DIV) && (b_ff == '0);
      lane_in[0].neg      = a_ff[DW-1] ^ b_ff[DW-1];
      lane_in[0].rem      = '0;
      lane_in[0].dq       = {a_mag, {FRAC_BITS{1'b0}}};
      lane_in[0].dvs      = b_mag;
   end

   // divider lanes, each up to Sps quotient bits further on
   for (genvar d = 1; d < NumLanes; d++) begin : g_div
      always_comb begin
         lane_in[d] = lane_ff[d-1];
         {lane_in[d].rem, lane_in[d].dq} = div_steps(lane_ff[d-1].rem, lane_ff[d-1].dq,
                                                     lane_ff[d-1].dvs, (d - 1) * Sps);
      end
   end

   for (genvar l = 0; l < NumLanes; l++) begin : g_lane
      always_ff @(posedge clock) begin
         if (rdy[l+1]) begin
            lane_ff[l] <= lane_in[l];
         end
      end
   end

   // output stage: sign the quotient and pick the divide result, 0 on a divide by zero, or the lane value
   assign quot = lane_ff[NumLanes-1].dq[DW-1:0];

   always_comb begin
      if (lane_ff[NumLanes-1].div_zero) begin
         value_in = '0;
      end else if (lane_ff[NumLanes-1].is_div) begin
         value_in = lane_ff[NumLanes-1].neg ? $signed(DW'(0 - quot)) : $signed(quot);
      end else begin
         value_in = lane_ff[NumLanes-1].value;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[Last]) begin
         value_ff    <= value_in;
         less_ff     <= lane_ff[NumLanes-1].less;
         equal_ff    <= lane_ff[NumLanes-1].equal;
         greater_ff  <= lane_ff[NumLanes-1].greater;
         div_zero_ff <= lane_ff[NumLanes-1].div_zero;
      end
   end

   assign rsp_valid     = valid_ff[Last];
   assign rsp_value     = value_ff;
   assign rsp_a_less    = less_ff;
   assign rsp_a_equal   = equal_ff;
   assign rsp_a_greater = greater_ff;
   assign rsp_div_zero  = div_zero_ff;

endmodule

>>> hw/rtl/fpa_checker.sv
module fpa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic signed [fpa_pkg::DATA_W-1:0] rsp_value,
   input logic                             rsp_a_less,
   input logic                             rsp_a_equal,
   input logic                             rsp_a_greater,
   input logic                             rsp_div_zero
);

   // a stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("stalled item changed");

   // exactly one compare flag
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_a_less, rsp_a_equal, rsp_a_greater}))
      else $error("compare flags not one-hot");

   // divide by zero returns zero
   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |-> rsp_value == '0)
      else $error("divide by zero value not zero");

   // back pressure only comes from the output side
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_stall |-> !req_stall)
      else $error("input stalled without output stall");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.*);

>>> bench/fixed_point_alu_tb.sv
module fixed_point_alu_tb;

   localparam int FRAC = fpa_pkg::FRAC_BITS_DEFAULT;
   // the pipeline holds the input register, the compute stage, the divider stages and the output register
   localparam int DRAIN_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 830;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [3:0]  action;
      logic [31:0] opa;
      logic [31:0] opb;
   } alu_op_type;

   typedef struct {
      logic [31:0] value;
      logic        lt;
      logic        eq;
      logic        gt;
      logic        dz;
   } alu_res_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [3:0]  req_action;
   logic signed [31:0] req_operand_a;
   logic signed [31:0] req_operand_b;
   logic        rsp_valid;
   logic        rsp_stall;
   logic signed [31:0] rsp_value;
   logic        rsp_a_less;
   logic        rsp_a_equal;
   logic        rsp_a_greater;
   logic        rsp_div_zero;

   alu_op_type  pending_ops[$];
   alu_res_type expected_results[$];
   int       error_count = 0;
   int       accepted_ops = 0;
   int       checked_results = 0;
   int       idle_cycles = 0;
   int       send_gap = 0;
   int       recv_gap = 0;
   int       hold_off = 0;
   bit       stimulus_done = 0;
   bit       hold_done = 0;

   fixed_point_alu #(.FRAC_BITS(FRAC)) dut (.*);

   // free-running clock, period 10
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // golden arithmetic for one item
   function automatic alu_res_type compute_result(alu_op_type op);
      logic signed [31:0]  a;
      logic signed [31:0]  b;
      logic signed [63:0]  wide;
      logic signed [63:0]  quot;
      alu_res_type r;
      a = op.opa;
      b = op.opb;
      r.dz = 1'b0;
      r.value = '0;
      case (op.action)
         fpa_pkg::ACT_ADD:   r.value = a + b;
         fpa_pkg::ACT_SUB:   r.value = a - b;
         fpa_pkg::ACT_MUL: begin
            wide = 64'(a) * 64'(b);
            wide = wide >>> FRAC;
            r.value = wide[31:0];
         end
         fpa_pkg::ACT_DIV: begin
            if (b == 0) begin
               r.dz = 1'b1;
            end else begin
               wide = 64'(a) <<< FRAC;
               quot = wide / 64'(b);  // sv division truncates toward zero
               r.value = quot[31:0];
            end
         end
         fpa_pkg::ACT_MIN:   r.value = (b < a) ? b : a;
         fpa_pkg::ACT_MAX:   r.value = (b > a) ? b : a;
         fpa_pkg::ACT_ROUND: r.value = $signed(a >>> FRAC) + 32'(a[FRAC-1]);
         fpa_pkg::ACT_INCR:  r.value = a + 1;
         fpa_pkg::ACT_DECR:  r.value = a - 1;
         default:   r.value = '0;
      endcase
      r.lt = a < b;
      r.eq = a == b;
      r.gt = a > b;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("mismatch on result %0d, %s: got %h, expected %h",
               checked_results, field, got, want);
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000 + $urandom_range(0, 3);
         1: return 32'h7fff_ffff - $urandom_range(0, 3);
         2: return $urandom_range(0, 2) - 1;
         3: return 32'($signed($urandom_range(0, 4096)) - 2048);
         4: return 32'($signed($urandom_range(0, 20'hfffff)) - 20'h80000);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_op(logic [3:0] act, logic [31:0] a, logic [31:0] b);
      alu_op_type op;
      op.action = act;
      op.opa = a;
      op.opb = b;
      pending_ops.push_back(op);
   endtask

   // directed corners, then random items
   initial begin
      logic [31:0] a;
      queue_op(fpa_pkg::ACT_ADD,   32'h7fff_ffff, 32'h0000_0001);   // wrap upward
      queue_op(fpa_pkg::ACT_SUB,   32'h8000_0000, 32'h0000_0001);   // wrap downward
      queue_op(fpa_pkg::ACT_MUL,   32'h8000_0000, 32'h8000_0000);
      queue_op(fpa_pkg::ACT_MUL,   32'hffff_ff00, 32'h0000_0080);
      queue_op(fpa_pkg::ACT_MUL,   32'h7fff_ffff, 32'h8000_0000);
      queue_op(fpa_pkg::ACT_DIV,   32'h0000_1234, 32'h0000_0000);   // divide by zero
      queue_op(fpa_pkg::ACT_DIV,   32'h8000_0000, 32'hffff_ffff);
      queue_op(fpa_pkg::ACT_DIV,   32'hffff_fd00, 32'h0000_0700);   // negative, truncation
      queue_op(fpa_pkg::ACT_DIV,   32'h7fff_ffff, 32'h0000_0001);
      queue_op(fpa_pkg::ACT_MIN,   32'h8000_0000, 32'h7fff_ffff);
      queue_op(fpa_pkg::ACT_MAX,   32'h8000_0000, 32'h7fff_ffff);
      queue_op(fpa_pkg::ACT_MIN,   32'h0000_0005, 32'h0000_0005);
      queue_op(fpa_pkg::ACT_ROUND, 32'h0000_0180, 32'h0);           // half bit set
      queue_op(fpa_pkg::ACT_ROUND, 32'hffff_fe80, 32'h0);
      queue_op(fpa_pkg::ACT_ROUND, 32'h7fff_ffff, 32'h7fff_ffff);
      queue_op(fpa_pkg::ACT_INCR,  32'h7fff_ffff, 32'h0);
      queue_op(fpa_pkg::ACT_DECR,  32'h8000_0000, 32'h0);
      queue_op(fpa_pkg::ACT_CMP,   32'hffff_ffff, 32'h0000_0000);
      queue_op(4'd10,     32'h1234_5678, 32'h1234_5678);   // undefined action
      queue_op(4'd15,     32'hffff_ffff, 32'h8000_0000);
      queue_op(fpa_pkg::ACT_DIV,   32'h0000_0000, 32'h0000_0000);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         a = random_operand();
         queue_op(4'($urandom_range(0, 15)), a,
                  ($urandom_range(0, 9) == 0) ? a : random_operand());
      end
   end

   // reset; the driver below presents items at the falling edge, random gaps between them
   initial begin
      req_valid = 1'b0;
      req_action = '0;
      req_operand_a = '0;
      req_operand_b = '0;
      rsp_stall = 1'b0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // accepted-at-posedge flag, sampled at the rising edge
   logic req_taken;
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken || !req_valid) begin
            // the slot is free: either idle or the last item went in
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               req_valid <= 1'b1;
               req_action <= pending_ops[0].action;
               req_operand_a <= pending_ops[0].opa;
               req_operand_b <= pending_ops[0].opb;
               void'(pending_ops.pop_front());
               // stretches without gaps now and then
               send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            end else begin
               req_valid <= 1'b0;
               stimulus_done <= 1'b1;
            end
         end
      end
   end

   // receiver stall: random per item, plus one long hold-off early on
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && accepted_ops >= 100) begin
            // hold the output back long enough for the pipeline to fill up
            rsp_stall <= (hold_off != HOLD_CYCLES);
            if (hold_off == HOLD_CYCLES) begin
               hold_done <= 1'b1;
            end
            hold_off <= hold_off + 1;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_valid)
               recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         end
      end
   end

   // monitor: input acceptance feeds the predictor, output acceptance is checked
   always @(posedge clock) begin
      alu_op_type  op;
      alu_res_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            op.action = req_action;
            op.opa = req_operand_a;
            op.opb = req_operand_b;
            expected_results.push_back(compute_result(op));
            accepted_ops++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected item", rsp_value, 'x);
            end else begin
               want = expected_results.pop_front();
               if (rsp_value !== want.value)
                  report_mismatch("value", rsp_value, want.value);
               if (rsp_a_less !== want.lt)
                  report_mismatch("a_less", rsp_a_less, want.lt);
               if (rsp_a_equal !== want.eq)
                  report_mismatch("a_equal", rsp_a_equal, want.eq);
               if (rsp_a_greater !== want.gt)
                  report_mismatch("a_greater", rsp_a_greater, want.gt);
               if (rsp_div_zero !== want.dz)
                  report_mismatch("div_zero", rsp_div_zero, want.dz);
            end
            checked_results++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // end of run and watchdog
   initial begin
      @(negedge reset);
      while (!(stimulus_done && expected_results.size() == 0)
             && idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: %0d items still expected", expected_results.size());
         $display("Simulation FAILED");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         $display("ran %0d items through all actions, with corner operands and",
                  accepted_ops);
         $display("random stalls on both sides; %0d results checked, %0d errors",
                  checked_results, error_count);
         if (error_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
         else
            $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
